// File: rtl/linear_probe_hash_table_defines.svh
// Assertion macros for the linear probe hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpht_pkg.sv
// Shared types, constants and hash step for the linear probe hash table
package lpht_pkg;

    localparam int DefCapacity   = 256;
    localparam int DefKeyBytes   = 8;
    localparam int DefValueWidth = 32;

    localparam logic [7:0]  MaxEntriesReset = 8'd128;
    localparam logic [63:0] HashOffset      = 64'hcbf29ce484222325;
    localparam logic [63:0] HashPrimeLow    = 64'h1b3;   // prime = 2^40 + 0x1b3

    localparam logic CmdSet = 1'b0;
    localparam logic CmdGet = 1'b1;

    localparam logic [2:0] StUpdated  = 3'd0;
    localparam logic [2:0] StInserted = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StHit      = 3'd3;
    localparam logic [2:0] StMiss     = 3'd4;
    localparam logic [2:0] StZero     = 3'd5;

    typedef struct packed {
        logic        command;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [31:0] value;
    } lpht_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        logic [7:0]  entry_count;
    } lpht_out_t;

    // normalized request plus its full hash, handed from front to back
    typedef struct packed {
        logic        command;
        logic [63:0] key;
        logic [3:0]  len;
        logic [31:0] value;
        logic [63:0] hash;
    } lpht_req_t;

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + 64'(x * HashPrimeLow);
    endfunction

endpackage

// File: rtl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lpht_front.sv
// Front end: accepts requests, normalizes the key and runs FNV-1a a byte per cycle
module lpht_front import lpht_pkg::*; #(
    parameter int KEY_BYTES = DefKeyBytes
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clearing,
    input  logic      in_valid,
    output logic      in_ready,
    input  lpht_in_t  in_data,
    output logic      push_valid,
    input  logic      push_ready,
    output lpht_req_t push_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HASH = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    lpht_req_t   req_reg, req_next;
    logic [2:0]  byte_reg, byte_next;
    logic [3:0]  norm_len;
    logic [63:0] norm_key;

    always_comb
    begin
        if (in_data.key_length == 4'd0)
        begin
            norm_len = 4'd1;
        end
        else if (in_data.key_length > 4'(KEY_BYTES))
        begin
            norm_len = 4'(KEY_BYTES);
        end
        else
        begin
            norm_len = in_data.key_length;
        end
        for (int i = 0; i < 8; i++)
        begin
            norm_key[i*8 +: 8] = (4'(i) < norm_len) ? in_data.key_bytes[i*8 +: 8] : 8'd0;
        end
    end

    assign in_ready   = (state_reg == S_IDLE) && !clearing;
    assign push_valid = (state_reg == S_PUSH);
    assign push_data  = req_reg;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        byte_next  = byte_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    req_next.command = in_data.command;
                    req_next.key     = norm_key;
                    req_next.len     = norm_len;
                    req_next.value   = in_data.value;
                    req_next.hash    = HashOffset;
                    byte_next        = 3'd0;
                    state_next       = S_HASH;
                end
            end
            S_HASH:
            begin
                req_next.hash = fnv_step(req_reg.hash, req_reg.key[byte_reg*8 +: 8]);
                byte_next     = byte_reg + 3'd1;
                if ({1'b0, byte_reg} + 4'd1 == req_reg.len)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        byte_reg <= byte_next;
    end

endmodule

// File: rtl/lpht_queue.sv
// Two-entry request queue between front and back
module lpht_queue import lpht_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  lpht_req_t push_data,
    output logic      pop_valid,
    input  logic      pop,
    output lpht_req_t pop_data
);

    lpht_req_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/lpht_back.sv
// Back end: clearing pass, probe walk over the slot RAM, update and result register
module lpht_back import lpht_pkg::*; #(
    parameter int CAPACITY    = DefCapacity,
    parameter int VALUE_WIDTH = DefValueWidth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] max_entries,
    output logic       clearing,
    input  logic       q_valid,
    output logic       q_pop,
    input  lpht_req_t  q_data,
    output logic       out_valid,
    input  logic       out_ready,
    output lpht_out_t  out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int RW = 4 + 64 + VALUE_WIDTH;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          n_reg, n_next;
    lpht_req_t              item_reg, item_next;
    logic [7:0]             count_reg, count_next;
    lpht_out_t              res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    lpht_out_t              out_data_reg, out_data_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr, ram_raddr;
    logic [RW-1:0]          ram_wdata, ram_rdata;
    logic [3:0]             r_len;
    logic [63:0]            r_key;
    logic [VALUE_WIDTH-1:0] r_val, item_val, q_val;

    assign r_len    = ram_rdata[RW-1 -: 4];
    assign r_key    = ram_rdata[VALUE_WIDTH +: 64];
    assign r_val    = ram_rdata[VALUE_WIDTH-1:0];
    assign item_val = VALUE_WIDTH'(item_reg.value);
    assign q_val    = VALUE_WIDTH'(q_data.value);

    assign clearing  = (state_reg == S_CLEAR);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    lpht_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = {4'(item_reg.len), item_reg.key, item_val};
        ram_raddr      = idx_reg + IW'(1);
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                idx_next  = idx_reg + IW'(1);
                if (idx_reg == IW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = q_data.hash[IW-1:0];
                if (q_valid)
                begin
                    item_next = q_data;
                    idx_next  = q_data.hash[IW-1:0];
                    n_next    = '0;
                    if (q_data.command == CmdSet && q_val == '0)
                    begin
                        res_next   = '{status: StZero, value_out: 32'd0, entry_count: count_reg};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                res_next = '{status: StMiss, value_out: 32'd0, entry_count: count_reg};
                if (r_len == 4'd0)
                begin
                    if (item_reg.command == CmdSet)
                    begin
                        if (count_reg >= max_entries)
                        begin
                            res_next.status = StFull;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            count_next           = count_reg + 8'd1;
                            res_next.status      = StInserted;
                            res_next.entry_count = count_reg + 8'd1;
                        end
                    end
                    state_next = S_DONE;
                end
                else if (r_len == item_reg.len && r_key == item_reg.key)
                begin
                    if (item_reg.command == CmdSet)
                    begin
                        ram_we          = 1'b1;
                        res_next.status = StUpdated;
                    end
                    else
                    begin
                        res_next.status    = StHit;
                        res_next.value_out = 32'(r_val);
                    end
                    state_next = S_DONE;
                end
                else if (n_reg == IW'(CAPACITY - 1))
                begin
                    // walked every slot without a match or a hole
                    if (item_reg.command == CmdSet)
                    begin
                        res_next.status = StFull;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                    n_next   = n_reg + IW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: rtl/linear_probe_hash_table.sv
// Top level of the linear probe hash table
//
//  channel | signals                          | direction
//  in      | in_valid, in_ready, in_data      | request in
//  out     | out_valid, out_ready, out_data   | result out
//  cfg     | cfg_we, cfg_wdata                | max_entries write
//
// After reset a clearing pass empties every slot; no request is taken until it
// ends. The front hashes the key one byte at a time (one multiply step per byte),
// then hands the request over, and takes no new request until the handover. The
// back end reads the slot RAM once per probe. The two parts overlap through a
// two-entry queue; a stalled output holds the back end, and the front too once
// the queue is full.
module linear_probe_hash_table import lpht_pkg::*; #(
    parameter int CAPACITY    = DefCapacity,
    parameter int KEY_BYTES   = DefKeyBytes,
    parameter int VALUE_WIDTH = DefValueWidth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lpht_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output lpht_out_t  out_data,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic [7:0] max_entries_reg;
    logic       clearing;
    logic       push_valid, push_ready, q_valid, q_pop;
    lpht_req_t  push_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MaxEntriesReset;
        end
        else if (cfg_we)
        begin
            max_entries_reg <= cfg_wdata;
        end
    end

    lpht_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clearing   (clearing),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lpht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    lpht_back #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_entries (max_entries_reg),
        .clearing    (clearing),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// File: rtl/lpht_checker.sv
// Port-level checker for the linear probe hash table, bound to the top level
`include "linear_probe_hash_table_defines.svh"

module lpht_port_checker import lpht_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input lpht_out_t out_data
);

    `LPHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
    `LPHT_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_data.status <= StZero, "undefined status code")
    `LPHT_ASSERT_NOW(a_insert_count, clk, rst_n, out_valid && out_data.status == StInserted, out_data.entry_count != 8'd0, "insert reported with empty table")
    `LPHT_ASSERT_NOW(a_value_rule, clk, rst_n, out_valid, (out_data.status == StHit) == (out_data.value_out != 32'd0), "value_out disagrees with hit status")

endmodule

bind linear_probe_hash_table lpht_port_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
